// ----- hdl/id_slot_table_defines.svh -----
// Assertion macros used by the slot table datapath.
// Each macro samples on the rising edge of clock and is disabled during reset.
`ifndef ID_SLOT_TABLE_DEFINES_SVH
`define ID_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication.
`define IST_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("id_slot_table: same-cycle check failed");

// Next-cycle implication.
`define IST_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("id_slot_table: next-cycle check failed");

`endif

// ----- hdl/ist_pkg.sv -----
package ist_pkg;

   localparam int SLOTS   = 64;
   localparam int ID_BITS = 31;
   localparam int IDX_W   = 6;   // slot_index width
   localparam int CNT_W   = 7;   // occupancy and slots_in_use width
   localparam int STAT_W  = 2;
   localparam int REQ_W   = 32;  // key padded to whole bytes
   localparam int RSP_W   = IDX_W + STAT_W + 1 + CNT_W;

   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(SLOTS);

   // Operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // Result status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_ZERO    = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CHECK = 4'b0010,
      S_SCAN  = 4'b0100,
      S_POST  = 4'b1000
   } state_type;

   typedef struct packed {
      logic load;          // latch the request
      logic start;         // rewind the scan
      logic scan;          // advance the scan pipeline
      logic finish_early;  // latch a result that needs no scan
      logic finish_scan;   // commit the scan outcome
      logic emit;          // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic early;         // request decided without a scan
      logic found;         // compared slot matches
      logic exhausted;     // last slot compared without a match
      logic out_free;      // output register can take a result
   } stat_type;

endpackage

// ----- hdl/ist_ctrl.sv -----
module ist_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ist_pkg::stat_type st,
   output ist_pkg::cmd_type  cmd
);
   import ist_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.start = 1'b1;
            if (st.early) begin
               cmd.finish_early = 1'b1;
               state_in         = S_POST;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (st.found || st.exhausted) begin
               cmd.finish_scan = 1'b1;
               state_in        = S_POST;
            end
         end
         S_POST: begin
            // hold the result until the output register frees up
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/ist_datapath.sv -----
`include "id_slot_table_defines.svh"

module ist_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ist_pkg::cmd_type                   cmd,
   output ist_pkg::stat_type                  st,
   input  logic [ist_pkg::REQ_W-1:0]          req_tdata,
   input  logic                               req_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ist_pkg::CNT_W-1:0]          csr_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ist_pkg::RSP_W-1:0]          rsp_tdata
);
   import ist_pkg::*;

   logic [ID_BITS-1:0] mem [SLOTS];
   logic [SLOTS-1:0]   vld_ff;

   logic [CNT_W-1:0]   csr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               func_ff;
   logic [ID_BITS-1:0] key_ff;

   logic [IDX_W-1:0]   addr_ff;
   logic               issue_ff;
   logic [ID_BITS-1:0] rd_data_ff;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               rd_live_ff;

   logic [IDX_W-1:0]   res_slot_ff;
   logic [STAT_W-1:0]  res_status_ff;
   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;

   logic [CNT_W-1:0]   cap;
   logic [CNT_W-1:0]   last_idx;
   logic [ID_BITS-1:0] entry;
   logic               match;
   logic               early;
   logic [STAT_W-1:0]  early_code;
   logic               mem_we;

   assign csr_ready = 1'b1;

   assign cap      = (csr_ff > CAP_RESET) ? CAP_RESET : csr_ff;
   assign last_idx = cap - CNT_W'(1);

   // an entry whose valid bit is clear reads as empty
   assign entry = rd_vld_ff ? rd_data_ff : '0;
   assign match = (func_ff == FUNC_REMOVE) ? (entry == key_ff) : (entry == '0);

   always_comb begin
      early      = 1'b1;
      early_code = ST_OK;
      if (key_ff == '0) begin
         early_code = ST_ZERO;
      end else if (func_ff == FUNC_INSERT && count_ff >= cap) begin
         early_code = ST_FULL;
      end else if (func_ff == FUNC_REMOVE && cap == '0) begin
         early_code = ST_MISSING;
      end else begin
         early = 1'b0;
      end
   end

   assign st.early     = early;
   assign st.found     = rd_live_ff && match;
   assign st.exhausted = rd_live_ff && !match && ({1'b0, rd_idx_ff} == last_idx);
   assign st.out_free  = !rsp_valid_ff || rsp_tready;

   assign mem_we = cmd.finish_scan && st.found && (func_ff == FUNC_INSERT);

   always_comb begin
      count_in = count_ff;
      if (cmd.finish_scan && st.found) begin
         if (func_ff == FUNC_INSERT) begin
            count_in = count_ff + CNT_W'(1);
         end else if (count_ff != '0) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= CAP_RESET;
         count_ff     <= '0;
         vld_ff       <= '0;
         issue_ff     <= 1'b0;
         rd_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            csr_ff <= csr_data;
         end
         count_ff <= count_in;
         if (cmd.finish_scan && st.found) begin
            vld_ff[rd_idx_ff] <= (func_ff == FUNC_INSERT);
         end
         if (cmd.start) begin
            issue_ff   <= 1'b1;
            rd_live_ff <= 1'b0;
         end else if (cmd.scan) begin
            rd_live_ff <= issue_ff;
            if (issue_ff && ({1'b0, addr_ff} == last_idx)) begin
               issue_ff <= 1'b0;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tuser;
         key_ff  <= req_tdata[ID_BITS-1:0];
      end
      if (cmd.start) begin
         addr_ff <= '0;
      end else if (cmd.scan && issue_ff) begin
         addr_ff   <= addr_ff + IDX_W'(1);
         rd_idx_ff <= addr_ff;
         rd_vld_ff <= vld_ff[addr_ff];
      end
      if (cmd.finish_early) begin
         res_slot_ff   <= '0;
         res_status_ff <= early_code;
      end else if (cmd.finish_scan) begin
         res_slot_ff   <= st.found ? rd_idx_ff : '0;
         res_status_ff <= st.found ? ST_OK :
                          ((func_ff == FUNC_INSERT) ? ST_FULL : ST_MISSING);
      end
      if (cmd.emit) begin
         rsp_data_ff <= {count_ff, (count_ff >= cap), res_status_ff, res_slot_ff};
      end
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[rd_idx_ff] <= key_ff;
      end
      rd_data_ff <= mem[addr_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `IST_ASSERT_IMP(a_found_excl, st.found, !st.exhausted)
   `IST_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(SLOTS))
   `IST_ASSERT_IMP(a_scan_in_range, cmd.scan && rd_live_ff, CNT_W'(rd_idx_ff) < cap)
   `IST_ASSERT_NXT(a_insert_counts, mem_we, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

// ----- hdl/id_slot_table.sv -----
// Timing: a request decided without a scan (zero key, table full, no capacity)
//   goes from S_CHECK straight to S_POST; others scan up to slots_in_use slots.
// Throughput: one request at a time; the slot scan reads one table entry per
//   cycle from the table memory until a match or the last slot in use.
// Reset: synchronous, active high; empties the table (valid bits clear at once),
//   zeroes the occupancy and sets slots_in_use to 64. No clearing pass follows.
module id_slot_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [ist_pkg::REQ_W-1:0] req_tdata,   // [30:0] key, [31] zero pad
   input  logic                      req_tuser,   // [0] func
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [ist_pkg::CNT_W-1:0] csr_data,    // slots_in_use
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [ist_pkg::RSP_W-1:0] rsp_tdata    // [5:0] slot_index, [7:6] status,
                                                  // [8] table_full, [15:9] occupancy
);
   import ist_pkg::*;

   cmd_type  cmd;
   stat_type st;

   ist_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   ist_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
